### design/vmeu_pkg.sv
// Package for the VM execute unit: opcodes, status codes and shared types.
// No dependencies.
`default_nettype none
package vmeu_pkg;
  localparam int WordBitsDef = 32;

  localparam logic [4:0] OP_JMP  = 5'h01;
  localparam logic [4:0] OP_JZ   = 5'h02;
  localparam logic [4:0] OP_JP   = 5'h03;
  localparam logic [4:0] OP_JN   = 5'h04;
  localparam logic [4:0] OP_JNZ  = 5'h05;
  localparam logic [4:0] OP_JNP  = 5'h06;
  localparam logic [4:0] OP_JNN  = 5'h07;
  localparam logic [4:0] OP_NOT  = 5'h08;
  localparam logic [4:0] OP_STOP = 5'h0F;
  localparam logic [4:0] OP_MOV  = 5'h10;
  localparam logic [4:0] OP_ADD  = 5'h11;
  localparam logic [4:0] OP_SUB  = 5'h12;
  localparam logic [4:0] OP_MUL  = 5'h13;
  localparam logic [4:0] OP_DIV  = 5'h14;
  localparam logic [4:0] OP_CMP  = 5'h15;
  localparam logic [4:0] OP_SHL  = 5'h16;
  localparam logic [4:0] OP_SHR  = 5'h17;
  localparam logic [4:0] OP_SAR  = 5'h18;
  localparam logic [4:0] OP_AND  = 5'h19;
  localparam logic [4:0] OP_OR   = 5'h1A;
  localparam logic [4:0] OP_XOR  = 5'h1B;
  localparam logic [4:0] OP_SWAP = 5'h1C;
  localparam logic [4:0] OP_LDL  = 5'h1D;
  localparam logic [4:0] OP_LDH  = 5'h1E;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIVZ  = 2'd1;
  localparam logic [1:0] ST_STOP  = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic mul_step;   // register the product
    logic div_start;  // start the divider
    logic finish;     // form and register the result
  } vmeu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_done;
  } vmeu_sts_t;
endpackage
`default_nettype wire

### design/vm_execute_unit_alu_branch.sv
// VM execute unit: ALU, condition flags, accumulator and jump resolution.
// Each item is captured and then executed; MUL first registers its product, and a DIV
// with a nonzero divisor first runs the radix-2 divider. The result is then registered
// once the result register is free. A new item is taken only after the last one's result
// is in the result register, as set by the capture/execute controller. Reset (rst_n, synchronous): flags,
// accumulator and segment base clear to 0. Depends on vmeu_pkg, vmeu_ctrl, vmeu_datapath.
`default_nettype none
module vm_execute_unit_alu_branch
  import vmeu_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDef
) (
  input  wire  logic                 clk,
  input  wire  logic                 rst_n,
  input  wire  logic                 cfg_valid,
  output logic                       cfg_ready,
  input  wire  logic [31:0]          cfg_code_segment_base,
  input  wire  logic                 in_valid,
  output logic                       in_ready,
  input  wire  logic [4:0]           in_op,
  input  wire  logic [WORD_BITS-1:0] in_operand_a,
  input  wire  logic [WORD_BITS-1:0] in_operand_b,
  input  wire  logic [31:0]          in_next_address,
  output logic                       out_valid,
  input  wire  logic                 out_ready,
  output logic                       out_write_a,
  output logic [WORD_BITS-1:0]       out_value_a,
  output logic                       out_write_b,
  output logic [WORD_BITS-1:0]       out_value_b,
  output logic [31:0]                out_new_address,
  output logic [1:0]                 out_status,
  output logic                       out_flag_negative,
  output logic                       out_flag_zero
);
  vmeu_cmd_t cmd;
  vmeu_sts_t sts;

  assign cfg_ready = 1'b1;

  vmeu_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  vmeu_datapath #(.WordBits(WORD_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_valid, .cfg_data(cfg_code_segment_base),
    .in_op, .in_operand_a, .in_operand_b, .in_next_address,
    .out_write_a, .out_value_a, .out_write_b, .out_value_b,
    .out_new_address, .out_status, .out_flag_negative, .out_flag_zero
  );
endmodule
`default_nettype wire

### design/vmeu_div.sv
// Radix-2 restoring divider on magnitudes, one quotient bit a cycle.
// Depends on vmeu_pkg.
`default_nettype none
module vmeu_div
  import vmeu_pkg::*;
#(
  parameter int WordBits = WordBitsDef
) (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  logic                start,
  input  wire  logic [WordBits-1:0] dividend,
  input  wire  logic [WordBits-1:0] divisor,
  output logic                      done,
  output logic [WordBits-1:0]       quotient,
  output logic [WordBits-1:0]       remainder
);
  localparam int CntBits = $clog2(WordBits + 1);

  logic [WordBits-1:0] q_r, q_nxt, rem_r, rem_nxt, d_r;
  logic [CntBits-1:0]  cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic [WordBits:0]   trial, diff;

  // One shift-subtract step per cycle.
  always_comb begin
    trial    = {rem_r, q_r[WordBits-1]};
    diff     = trial - {1'b0, d_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CntBits'(WordBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[WordBits]) begin
        rem_nxt = diff[WordBits-1:0];
        q_nxt   = {q_r[WordBits-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WordBits-1:0];
        q_nxt   = {q_r[WordBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntBits'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) d_r <= divisor;
  end

  assign done      = busy_r && (cnt_r == CntBits'(1));
  assign quotient  = q_nxt;
  assign remainder = rem_nxt;
endmodule
`default_nettype wire

### design/vmeu_datapath.sv
// Datapath of the VM execute unit: operand registers, ALU, multiplier,
// divider, flags, accumulator and result register. Depends on vmeu_pkg, vmeu_div.
`default_nettype none
module vmeu_datapath
  import vmeu_pkg::*;
#(
  parameter int WordBits = WordBitsDef
) (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  vmeu_cmd_t           cmd,
  output vmeu_sts_t                 sts,
  input  wire  logic                cfg_valid,
  input  wire  logic [31:0]         cfg_data,
  input  wire  logic [4:0]          in_op,
  input  wire  logic [WordBits-1:0] in_operand_a,
  input  wire  logic [WordBits-1:0] in_operand_b,
  input  wire  logic [31:0]         in_next_address,
  output logic                      out_write_a,
  output logic [WordBits-1:0]       out_value_a,
  output logic                      out_write_b,
  output logic [WordBits-1:0]       out_value_b,
  output logic [31:0]               out_new_address,
  output logic [1:0]                out_status,
  output logic                      out_flag_negative,
  output logic                      out_flag_zero
);
  localparam int HalfBits = WordBits / 2;
  localparam int ShBits   = $clog2(WordBits);

  logic [31:0]         base_r, next_r;
  logic [4:0]          op_r;
  logic [WordBits-1:0] a_r, b_r, prod_r, acc_r;
  logic                neg_r, zero_r;
  logic                div_done;

  // Code segment base register.
  always_ff @(posedge clk) begin
    if (!rst_n) base_r <= '0;
    else if (cfg_valid) base_r <= cfg_data;
  end

  // Operand capture and registered product.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
      next_r <= in_next_address;
    end
    if (cmd.mul_step) prod_r <= WordBits'(a_r * b_r);
  end

  assign sts.is_mul   = (op_r == OP_MUL);
  assign sts.is_div   = (op_r == OP_DIV) && (b_r != '0);
  assign sts.div_done = div_done;

  // Signed division on magnitudes.
  logic                na, nb;
  logic [WordBits-1:0] ma, mb, dq, dr;
  assign na = a_r[WordBits-1];
  assign nb = b_r[WordBits-1];
  assign ma = na ? -a_r : a_r;
  assign mb = nb ? -b_r : b_r;

  vmeu_div #(.WordBits(WordBits)) u_div (
    .clk, .rst_n,
    .start(cmd.div_start), .dividend(ma), .divisor(mb),
    .done(div_done), .quotient(dq), .remainder(dr)
  );

  // Shifter.
  logic                big;
  logic [ShBits-1:0]   sh;
  assign big = (b_r >= WordBits'(WordBits));
  assign sh  = b_r[ShBits-1:0];

  // Result selection.
  logic [WordBits-1:0] va, vb, diff;
  logic                wa, wb, fl, jump, wacc;
  logic [31:0]         addr;
  logic [1:0]          st;
  logic [1:0]          cc;
  always_comb begin
    va = '0; vb = '0; wa = 1'b0; wb = 1'b0; fl = 1'b0; jump = 1'b0;
    wacc = 1'b0; st = ST_OK; addr = next_r;
    cc = {neg_r, zero_r};
    diff = a_r - b_r;
    unique case (op_r)
      OP_JMP:  jump = 1'b1;
      OP_JZ:   jump = (cc == 2'b01);
      OP_JP:   jump = (cc == 2'b00);
      OP_JN:   jump = (cc == 2'b10);
      OP_JNZ:  jump = (cc == 2'b00) || (cc == 2'b10);
      OP_JNP:  jump = (cc == 2'b01) || (cc == 2'b10);
      OP_JNN:  jump = (cc == 2'b00) || (cc == 2'b01);
      OP_NOT:  begin va = ~a_r; wa = 1'b1; fl = 1'b1; end
      OP_STOP: begin st = ST_STOP; addr = '1; end
      OP_MOV:  begin va = b_r; wa = 1'b1; end
      OP_ADD:  begin va = a_r + b_r; wa = 1'b1; fl = 1'b1; end
      OP_SUB:  begin va = diff; wa = 1'b1; fl = 1'b1; end
      OP_MUL:  begin va = prod_r; wa = 1'b1; fl = 1'b1; end
      OP_DIV: begin
        if (b_r == '0) st = ST_DIVZ;
        else begin
          va = (na != nb) ? -dq : dq;
          wa = 1'b1; fl = 1'b1; wacc = 1'b1;
        end
      end
      OP_CMP:  fl = 1'b1;
      OP_SHL:  begin va = big ? '0 : (a_r << sh); wa = 1'b1; fl = 1'b1; end
      OP_SHR:  begin va = big ? '0 : (a_r >> sh); wa = 1'b1; fl = 1'b1; end
      OP_SAR: begin
        va = big ? {WordBits{a_r[WordBits-1]}} : WordBits'($signed(a_r) >>> sh);
        wa = 1'b1; fl = 1'b1;
      end
      OP_AND:  begin va = a_r & b_r; wa = 1'b1; fl = 1'b1; end
      OP_OR:   begin va = a_r | b_r; wa = 1'b1; fl = 1'b1; end
      OP_XOR:  begin va = a_r ^ b_r; wa = 1'b1; fl = 1'b1; end
      OP_SWAP: begin va = b_r; vb = a_r; wa = 1'b1; wb = 1'b1; end
      OP_LDL:  begin va = {a_r[WordBits-1:HalfBits], b_r[HalfBits-1:0]}; wa = 1'b1; end
      OP_LDH: begin
        va = {b_r[WordBits-HalfBits-1:0], a_r[HalfBits-1:0]};
        wa = 1'b1;
      end
      default: st = ST_UNSUP;
    endcase
    if (jump) addr = base_r | 32'(a_r);
  end

  // Flags, accumulator and result register.
  logic [WordBits-1:0] fsrc;
  assign fsrc = (op_r == OP_CMP) ? diff : va;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r  <= 1'b0;
      zero_r <= 1'b0;
      acc_r  <= '0;
    end else if (cmd.finish) begin
      if (fl) begin
        neg_r  <= fsrc[WordBits-1];
        zero_r <= (fsrc == '0);
      end
      if (wacc) acc_r <= na ? -dr : dr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_write_a     <= wa;
      out_value_a     <= va;
      out_write_b     <= wb;
      out_value_b     <= vb;
      out_new_address <= addr;
      out_status      <= st;
    end
  end
  assign out_flag_negative = neg_r;
  assign out_flag_zero     = zero_r;

  // The accumulator is internal state with no port of its own.
  logic acc_unused;
  assign acc_unused = ^acc_r;
endmodule
`default_nettype wire

### design/vmeu_ctrl.sv
// Controller of the VM execute unit: sequences capture, multiply, divide
// and result hand-off. Depends on vmeu_pkg.
`default_nettype none
module vmeu_ctrl
  import vmeu_pkg::*;
(
  input  wire  logic      clk,
  input  wire  logic      rst_n,
  input  wire  logic      in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire  logic      out_ready,
  output vmeu_cmd_t       cmd,
  input  wire  vmeu_sts_t sts
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       free;

  // The result register can take a new result when empty or being drained.
  assign free     = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.load  = in_valid && in_ready;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.is_mul) begin
          cmd.mul_step = 1'b1;
          state_nxt    = S_MUL;
        end else if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (free) begin
          cmd.finish = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      // Product or quotient is held stable here until the result register frees up.
      S_MUL: if (free) begin
        cmd.finish = 1'b1;
        ov_nxt     = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DIV: if (sts.div_done) state_nxt = S_MUL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire
